// ===== hdl/p2tc_pkg.sv =====
package p2tc_pkg;

    localparam int ROWS       = 8;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int BYTE_W     = 8;
    localparam int PIX_ROW_W  = 16;
    localparam int INDEX_W    = 4;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    typedef enum logic [1:0] {
        CMD_DEC_STORE,
        CMD_DEC_ROW,
        CMD_ENC_ROW,
        CMD_ENC_FLUSH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ROW_W-1:0]   row;
        logic [BYTE_W-1:0]  lo;
        logic [BYTE_W-1:0]  hi;
    } cmd_t;

    // plane bytes are MSB-leftmost, pixel k sits in bits 2k+1:2k
    function automatic logic [PIX_ROW_W-1:0] planes_to_row(input logic [BYTE_W-1:0] lo,
                                                           input logic [BYTE_W-1:0] hi);
        logic [PIX_ROW_W-1:0] r;
        r = '0;
        for (int k = 0; k < ROWS; k++)
        begin
            r[2*k]   = lo[ROWS-1-k];
            r[2*k+1] = hi[ROWS-1-k];
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] row_plane(input logic [PIX_ROW_W-1:0] r,
                                                    input logic                 high);
        logic [BYTE_W-1:0] b;
        b = '0;
        for (int k = 0; k < ROWS; k++)
        begin
            b[ROWS-1-k] = high ? r[2*k+1] : r[2*k];
        end
        return b;
    endfunction

endpackage

// ===== hdl/p2tc_front.sv =====
module p2tc_front
    import p2tc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic               direction_reg;
    logic [INDEX_W-1:0] pos_reg;
    logic [INDEX_W-1:0] pos_next;
    logic [BYTE_W-1:0]  in_byte;
    logic [PIX_ROW_W-1:0] in_row;
    logic [ROW_W-1:0]   row;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;
    assign in_byte       = s_axis_tdata[BYTE_W-1:0];
    assign in_row        = s_axis_tdata[BYTE_W +: PIX_ROW_W];
    assign row           = pos_reg[ROW_W-1:0];

    always_comb
    begin
        q_cmd.row = row;
        if (!direction_reg)
        begin
            q_cmd.kind = pos_reg[ROW_W] ? CMD_DEC_ROW : CMD_DEC_STORE;
            q_cmd.lo   = '0;
            q_cmd.hi   = in_byte;
            pos_next   = pos_reg + INDEX_W'(1);
        end
        else
        begin
            q_cmd.kind = (row == LAST_ROW) ? CMD_ENC_FLUSH : CMD_ENC_ROW;
            q_cmd.lo   = row_plane(in_row, 1'b0);
            q_cmd.hi   = row_plane(in_row, 1'b1);
            // encode always restarts at row 0 after the eighth row
            pos_next   = (row == LAST_ROW) ? '0 : {1'b0, row + ROW_W'(1)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                direction_reg <= cfg_data;
            end
            if (q_push)
            begin
                pos_reg <= pos_next;
            end
        end
    end

endmodule

// ===== hdl/p2tc_queue.sv =====
module p2tc_queue
    import p2tc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/p2tc_back.sv =====
module p2tc_back
    import p2tc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    logic [BYTE_W-1:0]    buf_mem [ROWS];
    logic                 buf_we;
    logic [ROW_W-1:0]     buf_waddr;
    logic [BYTE_W-1:0]    buf_wdata;
    logic [ROW_W-1:0]     buf_raddr;
    logic [BYTE_W-1:0]    buf_rdata;

    logic                 flush_reg;
    logic                 flush_next;
    logic [ROW_W-1:0]     flush_cnt_reg;
    logic [ROW_W-1:0]     flush_cnt_next;

    logic                 valid_reg;
    logic                 slot_free;
    logic                 emit;
    logic [BYTE_W-1:0]    byte_reg;
    logic [BYTE_W-1:0]    byte_next;
    logic [PIX_ROW_W-1:0] row_reg;
    logic [PIX_ROW_W-1:0] row_next;
    logic [INDEX_W-1:0]   index_reg;
    logic [INDEX_W-1:0]   index_next;
    logic                 last_reg;
    logic                 last_next;

    assign slot_free     = !valid_reg || m_axis_tready;
    assign buf_raddr     = flush_reg ? flush_cnt_reg : head.row;
    assign buf_rdata     = buf_mem[buf_raddr];
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - BYTE_W - PIX_ROW_W - INDEX_W){1'b0}},
                            index_reg, row_reg, byte_reg};

    always_comb
    begin
        pop            = 1'b0;
        emit           = 1'b0;
        buf_we         = 1'b0;
        buf_waddr      = head.row;
        buf_wdata      = head.hi;
        flush_next     = flush_reg;
        flush_cnt_next = flush_cnt_reg;
        byte_next      = '0;
        row_next       = '0;
        index_next     = {1'b0, head.row};
        last_next      = 1'b1;

        if (flush_reg)
        begin
            // high-plane bytes of the finished tile, one per cycle while the output slot is free
            if (slot_free)
            begin
                emit           = 1'b1;
                byte_next      = buf_rdata;
                index_next     = {1'b1, flush_cnt_reg};
                last_next      = (flush_cnt_reg == LAST_ROW);
                flush_cnt_next = flush_cnt_reg + ROW_W'(1);
                flush_next     = (flush_cnt_reg != LAST_ROW);
            end
        end
        else if (!empty)
        begin
            case (head.kind)
                CMD_DEC_STORE:
                begin
                    pop    = 1'b1;
                    buf_we = 1'b1;
                end
                CMD_DEC_ROW:
                begin
                    if (slot_free)
                    begin
                        pop      = 1'b1;
                        emit     = 1'b1;
                        row_next = planes_to_row(buf_rdata, head.hi);
                    end
                end
                CMD_ENC_ROW, CMD_ENC_FLUSH:
                begin
                    if (slot_free)
                    begin
                        pop       = 1'b1;
                        emit      = 1'b1;
                        buf_we    = 1'b1;
                        byte_next = head.lo;
                        if (head.kind == CMD_ENC_FLUSH)
                        begin
                            last_next      = 1'b0;
                            flush_next     = 1'b1;
                            flush_cnt_next = '0;
                        end
                    end
                end
                default:
                begin
                    pop = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        if (emit)
        begin
            byte_reg  <= byte_next;
            row_reg   <= row_next;
            index_reg <= index_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            flush_reg     <= 1'b0;
            flush_cnt_reg <= '0;
        end
        else
        begin
            flush_reg     <= flush_next;
            flush_cnt_reg <= flush_cnt_next;
            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/planar_2bpp_tile_codec.sv =====
// Converts 8x8 2bpp tiles between planar bytes (eight low-plane bytes, then
// eight high-plane bytes, bit 7 = leftmost pixel) and packed pixel rows
// (pixel k in bits 2k+1:2k). Direction is set through the cfg channel
// (0 = decode, 1 = encode) and may only change while the block is idle; a
// change mid-tile keeps the tile position. Decode: the first eight bytes of a
// tile give no result, the next eight each give one row. Encode: each row gives
// its low-plane byte at once; the eighth row also gives the eight buffered
// high-plane bytes, nine results in all, tlast on the final one. The input
// side feeds a four-entry command queue and takes one item per cycle while the
// queue has room; the output side delivers at most one result per cycle from
// an output register, so decode sustains one item per cycle while the receiver
// accepts, and encode is limited by that output port (16 bytes per 8 rows).
module planar_2bpp_tile_codec
    import p2tc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] in_byte, [23:8] in_row
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] out_byte, [23:8] out_row, [27:24] out_index, [31:28] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    cmd_t q_head;
    logic q_empty;

    p2tc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    p2tc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    p2tc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .empty         (q_empty),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sim/planar_2bpp_tile_codec_test.sv =====
`timescale 1ns / 100ps

module planar_2bpp_tile_codec_test;
    import p2tc_pkg::*;

    localparam logic DIR_DECODE    = 1'b0;
    localparam logic DIR_ENCODE    = 1'b1;
    localparam int   MAX_WAIT      = 16;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   CYCLE_LIMIT   = 500000;
    localparam int   RANDOM_ITEMS  = 300;
    localparam int   HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [BYTE_W-1:0]    out_byte;
        logic [PIX_ROW_W-1:0] out_row;
        logic [INDEX_W-1:0]   out_index;
        logic                 last;
    } tile_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data      = DIR_DECODE;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] in_byte, [23:8] in_row
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] out_byte, [23:8] out_row, [27:24] out_index, [31:28] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // shadow of the codec state
    logic [BYTE_W-1:0]  plane_bytes [ROWS] = '{default: '0};
    logic [INDEX_W-1:0] tile_pos      = '0;
    logic               direction_now = DIR_DECODE;
    tile_result_t       results_due [$];

    bit          src_steady  = 1'b0;
    bit          sink_steady = 1'b0;
    bit          sink_held   = 1'b0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned dir_writes   = 0;
    int unsigned cycle_count  = 0;

    planar_2bpp_tile_codec dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // bit 7 of each plane byte is pixel 0
    function automatic logic [PIX_ROW_W-1:0] weave_row(input logic [BYTE_W-1:0] lo,
                                                       input logic [BYTE_W-1:0] hi);
        logic [PIX_ROW_W-1:0] px;
        px = '0;
        for (int b = 0; b < BYTE_W; b++)
        begin
            px[2*(BYTE_W-1-b)]   = lo[b];
            px[2*(BYTE_W-1-b)+1] = hi[b];
        end
        return px;
    endfunction

    function automatic void unweave_row(input  logic [PIX_ROW_W-1:0] px,
                                        output logic [BYTE_W-1:0]    lo,
                                        output logic [BYTE_W-1:0]    hi);
        for (int b = 0; b < BYTE_W; b++)
        begin
            lo[b] = px[2*(BYTE_W-1-b)];
            hi[b] = px[2*(BYTE_W-1-b)+1];
        end
    endfunction

    function automatic tile_result_t make_result(input logic [BYTE_W-1:0]    b,
                                                 input logic [PIX_ROW_W-1:0] px,
                                                 input logic [INDEX_W-1:0]   idx,
                                                 input logic                 fin);
        tile_result_t r;
        r.out_byte  = b;
        r.out_row   = px;
        r.out_index = idx;
        r.last      = fin;
        return r;
    endfunction

    task automatic predict_tile_step(input logic [BYTE_W-1:0]    in_byte,
                                     input logic [PIX_ROW_W-1:0] in_row);
        logic [2:0]        row;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        row = tile_pos[2:0];
        if (direction_now == DIR_DECODE)
        begin
            // first half of a tile only fills the low plane
            if (!tile_pos[3])
                plane_bytes[row] = in_byte;
            else
                results_due.push_back(make_result('0, weave_row(plane_bytes[row], in_byte),
                                                  INDEX_W'(row), 1'b1));
            tile_pos = tile_pos + 1'b1;
        end
        else
        begin
            unweave_row(in_row, lo, hi);
            plane_bytes[row] = hi;
            results_due.push_back(make_result(lo, '0, INDEX_W'(row), row != 3'(ROWS - 1)));
            if (row == 3'(ROWS - 1))
            begin
                for (int i = 0; i < ROWS; i++)
                    results_due.push_back(make_result(plane_bytes[i], '0, INDEX_W'(ROWS + i),
                                                      i == ROWS - 1));
                tile_pos = '0;
            end
            else
                tile_pos = INDEX_W'(row) + 1'b1;
        end
    endtask

    task automatic push_item(input logic [BYTE_W-1:0] in_byte, input logic [PIX_ROW_W-1:0] in_row);
        int unsigned gap;
        gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {in_row, in_byte};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        predict_tile_step(in_byte, in_row);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        // decode stores give no result and may still sit in the queue
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= dir;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        direction_now = dir;
        dir_writes++;
    endtask

    // receiver refuses everything for a long stretch
    task automatic hold_sink();
        sink_held = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_held = 1'b0;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin : result_checker
        int unsigned  stall;
        tile_result_t got;
        tile_result_t want;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = make_result(m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tdata[27:24],
                                  m_axis_tlast);
                results_seen++;
                if (results_due.size() == 0)
                begin
                    $error("result 0x%0h arrived with nothing pending", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_field("out_byte", want.out_byte, got.out_byte);
                    compare_field("out_row", want.out_row, got.out_row);
                    compare_field("out_index", want.out_index, got.out_index);
                    compare_field("last", want.last, got.last);
                end
                stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (sink_held)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still pending",
                 cycle_count, results_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // low plane then half the rows; extreme and single-bit bytes
    task automatic test_decode_planes();
        logic [BYTE_W-1:0] seq [12];
        seq = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0,
                8'hFF, 8'h00, 8'h01, 8'h80};
        write_direction(DIR_DECODE);
        foreach (seq[i])
            push_item(seq[i], PIX_ROW_W'($urandom));
    endtask

    // switch at position 12: encode picks up at row 4 and flushes mixed planes
    task automatic test_encode_mid_tile();
        logic [PIX_ROW_W-1:0] rows [4];
        rows = '{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};
        write_direction(DIR_ENCODE);
        foreach (rows[i])
            push_item(BYTE_W'($urandom), rows[i]);
    endtask

    task automatic test_encode_tile();
        logic [PIX_ROW_W-1:0] rows [8];
        rows = '{16'h0003, 16'hC000, 16'h3333, 16'hCCCC, 16'h00FF, 16'hFF00,
                 PIX_ROW_W'($urandom), PIX_ROW_W'($urandom)};
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        foreach (rows[i])
            push_item(BYTE_W'($urandom), rows[i]);
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // output held off while encode requests keep coming: input must stall
    task automatic test_output_backpressure();
        write_direction(DIR_ENCODE);
        fork
            hold_sink();
        join_none
        src_steady = 1'b1;
        repeat (3 * ROWS) push_item(BYTE_W'($urandom), PIX_ROW_W'($urandom));
        src_steady = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned count;
        int unsigned to_end;
        logic        dir;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            dir = 1'($urandom_range(0, 1));
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            if (dir != direction_now || $urandom_range(0, 3) == 0)
                write_direction(dir);
            if ($urandom_range(0, 3) != 0)
            begin
                // run to the tile boundary, then some whole tiles
                if (direction_now == DIR_DECODE)
                    count = 2 * ROWS - int'(tile_pos) + 2 * ROWS * $urandom_range(0, 2);
                else
                begin
                    to_end = ROWS - int'(tile_pos[2:0]);
                    count  = to_end + ROWS * $urandom_range(0, 2);
                end
            end
            else
                count = $urandom_range(1, 11);
            repeat (count) push_item(BYTE_W'($urandom), PIX_ROW_W'($urandom));
            sent += count;
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_decode_planes();
        test_encode_mid_tile();
        test_encode_tile();
        test_output_backpressure();
        test_random_traffic();
        drain_results();
        $display("Sent %0d requests, checked %0d results, %0d direction writes",
                 items_sent, results_seen, dir_writes);
        $display("Covered decode and encode tiles, mid-tile switches and a long output stall");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/p2tc_pkg.sv
hdl/p2tc_front.sv
hdl/p2tc_queue.sv
hdl/p2tc_back.sv
hdl/planar_2bpp_tile_codec.sv
sim/planar_2bpp_tile_codec_test.sv
